FILE: src/smel_pkg.sv
`default_nettype none

package smel_pkg;

    localparam int MAX_SECTION_COLUMNS = 32;
    localparam int MAX_SECTION_SIZE    = 64;
    localparam int MAX_BANDS           = 64;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 20;
    localparam int TOTAL_W    = 25;
    localparam int COL_W      = $clog2(MAX_SECTION_COLUMNS);
    localparam int XPOS_W     = $clog2(MAX_SECTION_SIZE);
    localparam int ROW_W      = $clog2(MAX_SECTION_SIZE);
    localparam int BAND_W     = $clog2(MAX_BANDS);
    localparam int SIZE_CFG_W = 7;
    localparam int COLS_CFG_W = 6;
    localparam int ROWS_CFG_W = 7;
    localparam int AREA_W     = 13;
    localparam int MEAN_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int REM_W      = SUM_W - FRAC_W;
    localparam int DIV_CNT_W  = $clog2(MEAN_W);
    localparam int EDGE_W     = 6;
    localparam int PROD_W     = SUM_W + COLS_CFG_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_SECTION_WIDTH   = 2'd0;
    localparam logic [1:0] REG_SECTION_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_SECTION_COLUMNS = 2'd2;
    localparam logic [1:0] REG_SECTION_ROWS    = 2'd3;

    localparam logic [SIZE_CFG_W-1:0] RST_SECTION_WIDTH   = 7'd8;
    localparam logic [SIZE_CFG_W-1:0] RST_SECTION_HEIGHT  = 7'd8;
    localparam logic [COLS_CFG_W-1:0] RST_SECTION_COLUMNS = 6'd32;
    localparam logic [ROWS_CFG_W-1:0] RST_SECTION_ROWS    = 7'd16;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_FLUSH,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_OUT,
        ST_DONE
    } state_t;

    // effective (clamped) configuration
    typedef struct packed {
        logic [SIZE_CFG_W-1:0] width;
        logic [SIZE_CFG_W-1:0] height;
        logic [COLS_CFG_W-1:0] columns;
        logic [ROWS_CFG_W-1:0] rows;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic walk_rd;
        logic div_start;
        logic out_load;
        logic band_done;
    } cmd_t;

    typedef struct packed {
        logic band_end;
        logic walk_last;
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic [SIZE_CFG_W-1:0] clamp_size(input logic [SIZE_CFG_W-1:0] v);
        logic [SIZE_CFG_W-1:0] r;
        if (v == '0) begin
            r = SIZE_CFG_W'(1);
        end else if (v > SIZE_CFG_W'(MAX_SECTION_SIZE)) begin
            r = SIZE_CFG_W'(MAX_SECTION_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [COLS_CFG_W-1:0] clamp_cols(input logic [COLS_CFG_W-1:0] v);
        logic [COLS_CFG_W-1:0] r;
        if (v == '0) begin
            r = COLS_CFG_W'(1);
        end else if (v > COLS_CFG_W'(MAX_SECTION_COLUMNS)) begin
            r = COLS_CFG_W'(MAX_SECTION_COLUMNS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [ROWS_CFG_W-1:0] clamp_rows(input logic [ROWS_CFG_W-1:0] v);
        logic [ROWS_CFG_W-1:0] r;
        if (v == '0) begin
            r = ROWS_CFG_W'(1);
        end else if (v > ROWS_CFG_W'(MAX_BANDS)) begin
            r = ROWS_CFG_W'(MAX_BANDS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/section_mean_edge_locator.sv
`default_nettype none
// Pixels: one per cycle while a band fills; each passes through the accumulate stage
// register into the section sum RAM. Band end: per section column READ, LOAD, DIV and
// OUT (mean = sum*256/area, one quotient bit a cycle), between FLUSH and DONE, plus any
// output stalls; during all of it no pixel is taken.
// Reset (aresetn low, synchronous): registers to 8/8/32/16, counters, sums and output cleared.
// Any register write restarts the region: counters and sums are cleared as at reset.

module section_mean_edge_locator
    import smel_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB-style configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // pixel requests
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIX_W-1:0]      s_pixel,
    // result requests
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [BAND_W-1:0]          m_band_index,
    output logic [COL_W-1:0]           m_column_index,
    output logic [MEAN_W-1:0]          m_mean_q8,
    output logic [EDGE_W-1:0]          m_edge_index,
    output logic                       m_last_of_band
);

    // raw register values, read back as written
    logic [SIZE_CFG_W-1:0] width_reg;
    logic [SIZE_CFG_W-1:0] height_reg;
    logic [COLS_CFG_W-1:0] columns_reg;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic                  cfg_wr;
    logic [1:0]            reg_idx;
    cfg_t                  cfg;
    cmd_t                  cmd;
    status_t               status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RST_SECTION_WIDTH;
            height_reg  <= RST_SECTION_HEIGHT;
            columns_reg <= RST_SECTION_COLUMNS;
            rows_reg    <= RST_SECTION_ROWS;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SECTION_WIDTH:   width_reg   <= pwdata[SIZE_CFG_W-1:0];
                REG_SECTION_HEIGHT:  height_reg  <= pwdata[SIZE_CFG_W-1:0];
                REG_SECTION_COLUMNS: columns_reg <= pwdata[COLS_CFG_W-1:0];
                REG_SECTION_ROWS:    rows_reg    <= pwdata[ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SECTION_WIDTH:   prdata = APB_DATA_W'(width_reg);
            REG_SECTION_HEIGHT:  prdata = APB_DATA_W'(height_reg);
            REG_SECTION_COLUMNS: prdata = APB_DATA_W'(columns_reg);
            REG_SECTION_ROWS:    prdata = APB_DATA_W'(rows_reg);
            default:             prdata = '0;
        endcase
    end

    // out-of-range settings saturate to the legal range
    assign cfg.width   = clamp_size(width_reg);
    assign cfg.height  = clamp_size(height_reg);
    assign cfg.columns = clamp_cols(columns_reg);
    assign cfg.rows    = clamp_rows(rows_reg);

    smel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_wr),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    smel_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .restart        (cfg_wr),
        .cmd            (cmd),
        .status         (status),
        .s_pixel        (s_pixel),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_band_index   (m_band_index),
        .m_column_index (m_column_index),
        .m_mean_q8      (m_mean_q8),
        .m_edge_index   (m_edge_index),
        .m_last_of_band (m_last_of_band)
    );

endmodule

`default_nettype wire

FILE: src/smel_ram.sv
`default_nettype none

module smel_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/smel_div.sv
`default_nettype none

module smel_div
    import smel_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  dividend,
    input  wire logic [AREA_W-1:0] divisor,
    output logic                   done,
    output logic [MEAN_W-1:0]      quotient
);

    // restoring divider, one quotient bit per cycle; computes (dividend << 8) / divisor
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [MEAN_W-1:0]    quo_reg, quo_next;
    logic [MEAN_W-1:0]    low_reg, low_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_W:0]       shifted;
    logic [REM_W+1:0]     diff;
    logic                 ge;

    assign shifted = {rem_reg, low_reg[MEAN_W-1]};
    assign diff    = {1'b0, shifted} - {1'b0, divisor};
    assign ge      = ~diff[REM_W+1];

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = dividend[SUM_W-1:FRAC_W];
            low_next  = {dividend[FRAC_W-1:0], {(MEAN_W-FRAC_W){1'b0}}};
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            quo_next = {quo_reg[MEAN_W-2:0], ge};
            low_next = {low_reg[MEAN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(MEAN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        low_reg <= low_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/smel_datapath.sv
`default_nettype none

module smel_datapath
    import smel_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              restart,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic [PIX_W-1:0]  s_pixel,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic [BAND_W-1:0]      m_band_index,
    output logic [COL_W-1:0]       m_column_index,
    output logic [MEAN_W-1:0]      m_mean_q8,
    output logic [EDGE_W-1:0]      m_edge_index,
    output logic                   m_last_of_band
);

    // position counters
    logic [XPOS_W-1:0]  x_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [COL_W-1:0]   walk_j_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [AREA_W-1:0]  area_reg;
    logic               x_last, col_last, row_last, band_last;

    // accumulate stage and forwarding
    logic               acc_vld_reg;
    logic [COL_W-1:0]   acc_col_reg;
    logic [PIX_W-1:0]   acc_pix_reg;
    logic               fwd_vld_reg;
    logic [COL_W-1:0]   last_addr_reg;
    logic [SUM_W-1:0]   last_data_reg;
    logic [SUM_W-1:0]   acc_base;
    logic [SUM_W-1:0]   acc_sum;

    // sum store
    logic [MAX_SECTION_COLUMNS-1:0] sum_vld_reg;
    logic                           rd_vld_reg;
    logic [COL_W-1:0]               ram_raddr;
    logic [SUM_W-1:0]               ram_rdata;
    logic [SUM_W-1:0]               walk_sum;

    // band-end walk
    logic [SUM_W-1:0]   sum_reg;
    logic               hit_reg;
    logic               edge_found_reg;
    logic [EDGE_W-1:0]  edge_reg;
    logic [EDGE_W-1:0]  edge_val;
    logic [PROD_W-1:0]  product;
    logic               div_done;
    logic [MEAN_W-1:0]  quotient;

    // output register
    logic               m_valid_reg;
    logic [BAND_W-1:0]  m_band_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic [MEAN_W-1:0]  m_mean_reg;
    logic [EDGE_W-1:0]  m_edge_reg;
    logic               m_last_reg;

    assign x_last    = (x_reg == cfg.width[XPOS_W-1:0] - 1'b1);
    assign col_last  = (col_reg == cfg.columns[COL_W-1:0] - 1'b1);
    assign row_last  = (row_reg == cfg.height[ROW_W-1:0] - 1'b1);
    assign band_last = (band_reg == cfg.rows[BAND_W-1:0] - 1'b1);

    assign acc_base = (fwd_vld_reg && (last_addr_reg == acc_col_reg)) ? last_data_reg
                    : (rd_vld_reg ? ram_rdata : '0);
    assign acc_sum  = acc_base + SUM_W'(acc_pix_reg);
    assign walk_sum = rd_vld_reg ? ram_rdata : '0;
    assign ram_raddr = cmd.walk_rd ? walk_j_reg : col_reg;

    smel_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SECTION_COLUMNS)
    ) u_sums (
        .aclk  (aclk),
        .we    (acc_vld_reg),
        .waddr (acc_col_reg),
        .wdata (acc_sum),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smel_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (walk_sum),
        .divisor  (area_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign product  = PROD_W'(sum_reg) * PROD_W'(cfg.columns);
    assign edge_val = edge_found_reg ? edge_reg
                    : (hit_reg ? EDGE_W'(walk_j_reg) : EDGE_W'(cfg.columns));

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            x_reg          <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            band_reg       <= '0;
            walk_j_reg     <= '0;
            total_reg      <= '0;
            sum_vld_reg    <= '0;
            edge_found_reg <= 1'b0;
        end else begin
            if (cmd.take) begin
                total_reg <= total_reg + TOTAL_W'(s_pixel);
                if (x_last) begin
                    x_reg <= '0;
                    if (col_last) begin
                        col_reg <= '0;
                        row_reg <= row_last ? '0 : row_reg + 1'b1;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end else begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            if (acc_vld_reg) begin
                sum_vld_reg[acc_col_reg] <= 1'b1;
            end
            if (cmd.out_load) begin
                walk_j_reg <= walk_j_reg + 1'b1;
                if (!edge_found_reg && hit_reg) begin
                    edge_found_reg <= 1'b1;
                end
            end
            if (cmd.band_done) begin
                walk_j_reg     <= '0;
                total_reg      <= '0;
                sum_vld_reg    <= '0;
                edge_found_reg <= 1'b0;
                band_reg       <= band_last ? '0 : band_reg + 1'b1;
            end
        end
        if (cmd.out_load && !edge_found_reg && hit_reg) begin
            edge_reg <= EDGE_W'(walk_j_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg <= 1'b0;
            fwd_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_vld_reg <= cmd.take;
            fwd_vld_reg <= acc_vld_reg;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        acc_col_reg   <= col_reg;
        acc_pix_reg   <= s_pixel;
        last_addr_reg <= acc_col_reg;
        last_data_reg <= acc_sum;
        rd_vld_reg    <= sum_vld_reg[ram_raddr];
        area_reg      <= AREA_W'(cfg.width) * AREA_W'(cfg.height);
        hit_reg       <= product > PROD_W'(total_reg);
        if (cmd.div_start) begin
            sum_reg <= walk_sum;
        end
        if (cmd.out_load) begin
            m_band_reg <= band_reg;
            m_col_reg  <= walk_j_reg;
            m_mean_reg <= quotient;
            m_edge_reg <= status.walk_last ? edge_val : '0;
            m_last_reg <= status.walk_last;
        end
    end

    assign status.band_end  = x_last & col_last & row_last;
    assign status.walk_last = (walk_j_reg == cfg.columns[COL_W-1:0] - 1'b1);
    assign status.div_done  = div_done;
    assign status.out_free  = ~m_valid_reg | m_ready;

    assign m_valid        = m_valid_reg;
    assign m_band_index   = m_band_reg;
    assign m_column_index = m_col_reg;
    assign m_mean_q8      = m_mean_reg;
    assign m_edge_index   = m_edge_reg;
    assign m_last_of_band = m_last_reg;

endmodule

`default_nettype wire

FILE: src/smel_ctrl.sv
`default_nettype none

module smel_ctrl
    import smel_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    restart,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM: begin
                if (s_valid && status.band_end) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: state_next = ST_READ;
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = status.walk_last ? ST_DONE : ST_READ;
                end
            end
            ST_DONE:  state_next = ST_ACCUM;
            default:  state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_ACCUM: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_READ:  cmd.walk_rd   = 1'b1;
            ST_LOAD:  cmd.div_start = 1'b1;
            ST_OUT:   cmd.out_load  = status.out_free;
            ST_DONE:  cmd.band_done = 1'b1;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

// Bench for section_mean_edge_locator: pixel requests go in, per-section mean
// requests come out and are checked against a predictor kept in this file.
module tb_top;
    import smel_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    // watchdog limit on the whole run
    localparam int CYCLE_LIMIT   = 1_000_000;
    // pixel pipeline is two deep; give it room before touching registers
    localparam int SETTLE_CYCLES = 40;
    // room for a 32-column band walk
    localparam int TAIL_CYCLES   = 700;
    localparam int RANDOM_PIXELS = 100;
    localparam int MAX_REPORTS   = 40;

    typedef enum int {
        PIX_NOISE,
        PIX_STEP,
        PIX_FLAT,
        PIX_FULL
    } pixel_mode_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [COL_W-1:0]  column;
        logic [MEAN_W-1:0] mean;
        logic [EDGE_W-1:0] edge_col;
        logic              last;
    } section_result_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BAND_W-1:0]     m_band_index;
    logic [COL_W-1:0]      m_column_index;
    logic [MEAN_W-1:0]     m_mean_q8;
    logic [EDGE_W-1:0]     m_edge_index;
    logic                  m_last_of_band;

    // bench control
    int unsigned cycle_count = 0;
    int unsigned errors      = 0;
    bit          idle_on     = 1'b1;
    int unsigned stall_left  = 0;

    // expected section means, oldest first
    section_result_t pending_means[$];
    section_result_t head;

    // predictor state: raw register contents plus region position.
    // Row and band counters carry one bit more than the block so the increment
    // past the limit compares correctly before it wraps.
    logic [SIZE_CFG_W-1:0] cfg_width;
    logic [SIZE_CFG_W-1:0] cfg_height;
    logic [COLS_CFG_W-1:0] cfg_columns;
    logic [ROWS_CFG_W-1:0] cfg_rows;
    logic [SUM_W-1:0]      band_sums [MAX_SECTION_COLUMNS];
    logic [11:0]           x_pos;
    logic [6:0]            row_pos;
    logic [6:0]            band_pos;

    always #HALF_PERIOD aclk = ~aclk;

    section_mean_edge_locator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel        (s_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_band_index   (m_band_index),
        .m_column_index (m_column_index),
        .m_mean_q8      (m_mean_q8),
        .m_edge_index   (m_edge_index),
        .m_last_of_band (m_last_of_band)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned saturate(input int unsigned v, input int unsigned hi);
        if (v < 1) begin
            return 1;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    task automatic restart_region();
        foreach (band_sums[j]) begin
            band_sums[j] = '0;
        end
        x_pos    = '0;
        row_pos  = '0;
        band_pos = '0;
    endtask

    task automatic reset_model();
        cfg_width   = RST_SECTION_WIDTH;
        cfg_height  = RST_SECTION_HEIGHT;
        cfg_columns = RST_SECTION_COLUMNS;
        cfg_rows    = RST_SECTION_ROWS;
        restart_region();
    endtask

    // Accumulate one pixel; on the band's last pixel queue one mean per column.
    task automatic predict_pixel(input logic [PIX_W-1:0] pix);
        int unsigned       w;
        int unsigned       h;
        int unsigned       cols;
        int unsigned       bands;
        int unsigned       line_len;
        int unsigned       col;
        int unsigned       edge_col;
        longint unsigned   total;
        longint unsigned   area;
        section_result_t   res;
        w        = saturate(cfg_width, MAX_SECTION_SIZE);
        h        = saturate(cfg_height, MAX_SECTION_SIZE);
        cols     = saturate(cfg_columns, MAX_SECTION_COLUMNS);
        bands    = saturate(cfg_rows, MAX_BANDS);
        line_len = w * cols;
        if (x_pos >= line_len) x_pos = '0;
        if (row_pos >= h) row_pos = '0;
        if (band_pos >= bands) band_pos = '0;

        col = x_pos / w;
        band_sums[col] = band_sums[col] + pix;   // 20-bit wrap

        x_pos = x_pos + 1;
        if (x_pos < line_len) return;
        x_pos   = '0;
        row_pos = row_pos + 1;
        if (row_pos < h) return;
        row_pos = '0;

        // band complete: edge is the first section above the band average
        total = 0;
        for (int j = 0; j < cols; j++) begin
            total += band_sums[j];
        end
        edge_col = cols;
        for (int j = 0; j < cols; j++) begin
            if (longint'(band_sums[j]) * cols > total) begin
                edge_col = j;
                break;
            end
        end

        area = w * h;
        for (int j = 0; j < cols; j++) begin
            res.band     = band_pos[BAND_W-1:0];
            res.column   = COL_W'(j);
            res.mean     = MEAN_W'({band_sums[j], 8'h00} / area);
            res.last     = (j + 1 == cols);
            res.edge_col = res.last ? EDGE_W'(edge_col) : '0;
            pending_means = {pending_means, res};
        end

        foreach (band_sums[j]) begin
            band_sums[j] = '0;
        end
        band_pos = band_pos + 1;
        if (band_pos >= bands) band_pos = '0;
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // APB write: setup then access; lands on the edge where pready is high.
    task automatic write_register(input logic [1:0] index, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (index)
            REG_SECTION_WIDTH:   cfg_width   = value[SIZE_CFG_W-1:0];
            REG_SECTION_HEIGHT:  cfg_height  = value[SIZE_CFG_W-1:0];
            REG_SECTION_COLUMNS: cfg_columns = value[COLS_CFG_W-1:0];
            REG_SECTION_ROWS:    cfg_rows    = value[ROWS_CFG_W-1:0];
            default: ;
        endcase
        restart_region();
    endtask

    // Sometimes fill the bits above the field; the block must ignore them.
    function automatic logic [APB_DATA_W-1:0] with_junk(input int unsigned v, input int fw);
        logic [APB_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? ($urandom << fw) : '0;
        return junk | APB_DATA_W'(v);
    endfunction

    // Wait for every expected mean, let the pipeline empty, then program all four.
    task automatic set_sections(input int unsigned w, input int unsigned h,
                                input int unsigned c, input int unsigned r);
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_register(REG_SECTION_WIDTH,   with_junk(w, SIZE_CFG_W));
        write_register(REG_SECTION_HEIGHT,  with_junk(h, SIZE_CFG_W));
        write_register(REG_SECTION_COLUMNS, with_junk(c, COLS_CFG_W));
        write_register(REG_SECTION_ROWS,    with_junk(r, ROWS_CFG_W));
    endtask

    // One pixel request. Returns in the step where it was taken; valid stays
    // high into the next request unless an idle burst is drawn.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(pix);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Program a region and stream count pixels shaped by mode. pause_at >= 0
    // holds the sender before that pixel until every mean has come back.
    task automatic run_region(input int unsigned w, input int unsigned h,
                              input int unsigned c, input int unsigned r,
                              input int count, input pixel_mode_t mode, input int pause_at);
        int unsigned      eff_w;
        int unsigned      eff_c;
        int unsigned      line_len;
        int unsigned      step_at;
        int unsigned      col;
        logic [PIX_W-1:0] low;
        logic [PIX_W-1:0] high;
        logic [PIX_W-1:0] level;
        logic [PIX_W-1:0] pix;
        set_sections(w, h, c, r);
        eff_w    = saturate(w & 'h7F, MAX_SECTION_SIZE);
        eff_c    = saturate(c & 'h3F, MAX_SECTION_COLUMNS);
        line_len = eff_w * eff_c;
        step_at  = $urandom_range(0, eff_c);
        low      = PIX_W'($urandom_range(0, 127));
        high     = PIX_W'($urandom_range(128, 255));
        level    = PIX_W'($urandom);
        for (int i = 0; i < count; i++) begin
            col = (i % line_len) / eff_w;
            case (mode)
                // dark left, bright right: puts the edge at a chosen column
                PIX_STEP: pix = ((col >= step_at) ? high : low) ^ PIX_W'($urandom_range(0, 3));
                PIX_FLAT: pix = level;
                PIX_FULL: pix = '1;
                default:  pix = rand_pixel();
            endcase
            if (i == pause_at) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_means.size() != 0);
            end
            send_pixel(pix);
        end
        s_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready bursts and the scoreboard
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_means.size() == 0) begin
                report_mismatch($sformatf("unexpected mean band %0d col %0d",
                                          m_band_index, m_column_index));
            end else begin
                head = pending_means.pop_front();
                if (m_band_index !== head.band)
                    report_mismatch($sformatf("band_index got %0d want %0d",
                                              m_band_index, head.band));
                if (m_column_index !== head.column)
                    report_mismatch($sformatf("band %0d column_index got %0d want %0d",
                                              head.band, m_column_index, head.column));
                if (m_mean_q8 !== head.mean)
                    report_mismatch($sformatf("band %0d col %0d mean_q8 got %0d want %0d",
                                              head.band, head.column, m_mean_q8, head.mean));
                if (m_edge_index !== head.edge_col)
                    report_mismatch($sformatf("band %0d col %0d edge_index got %0d want %0d",
                                              head.band, head.column, m_edge_index,
                                              head.edge_col));
                if (m_last_of_band !== head.last)
                    report_mismatch($sformatf("band %0d col %0d last_of_band got %0b want %0b",
                                              head.band, head.column, m_last_of_band, head.last));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[section_mean_edge_locator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // A partial band at reset settings must vanish on a write; then
    // single-pixel bands check band numbering and the wrap to band 0.
    task automatic test_restart_on_write();
        logic [PIX_W-1:0] seq [3];
        seq = '{8'd0, 8'd255, 8'd77};
        for (int i = 0; i < 5; i++) begin
            send_pixel(rand_pixel());
        end
        s_valid <= 1'b0;
        set_sections(1, 1, 1, 2);
        foreach (seq[i]) begin
            send_pixel(seq[i]);
        end
        s_valid <= 1'b0;
    endtask

    // Edge search on four 1x1 sections: edge in the middle, no section
    // above average (index equals column count), edge at column 0.
    task automatic test_edge_search();
        logic [PIX_W-1:0] seq [12];
        seq = '{8'd0, 8'd0, 8'd255, 8'd0,
                8'd9, 8'd9, 8'd9, 8'd9,
                8'd255, 8'd0, 8'd0, 8'd0};
        set_sections(1, 1, 4, 3);
        foreach (seq[i]) begin
            send_pixel(seq[i]);
        end
        s_valid <= 1'b0;
    endtask

    // Zero in every register saturates to one.
    task automatic test_register_saturation();
        set_sections(0, 0, 0, 0);
        send_pixel(8'd200);
        send_pixel(8'd1);
        s_valid <= 1'b0;
    endtask

    // The largest settings, all reached through out-of-range writes,
    // each run for 64 or 70 pixels to keep the run short.
    task automatic test_large_sections();
        run_region(127, 1, 1, 1, 64, PIX_FULL, -1);     // width saturates to 64, largest mean
        run_region(1, 127, 1, 1, 64, PIX_NOISE, -1);    // height saturates to 64
        run_region(1, 1, 63, 2, 64, PIX_STEP, -1);      // 32 columns, two bands
        run_region(1, 1, 1, 127, 70, PIX_NOISE, -1);    // 64 bands, band index wraps
    endtask

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(65, 127);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic int unsigned pick_columns();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(33, 63);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int unsigned pick_rows();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(65, 127);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Small random regions: whole bands mostly, sometimes a partial band
    // that the next write throws away. One hold-off mid-way.
    task automatic test_random_regions();
        int          sent;
        int          count;
        int          pause_at;
        bit          paused;
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned band_px;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_PIXELS) begin
            w = pick_size();
            h = pick_size();
            c = pick_columns();
            r = pick_rows();
            band_px = saturate(w & 'h7F, MAX_SECTION_SIZE) * saturate(h & 'h7F, MAX_SECTION_SIZE)
                      * saturate(c & 'h3F, MAX_SECTION_COLUMNS);
            if (band_px > 256) begin
                c = 1;
                band_px = saturate(w & 'h7F, MAX_SECTION_SIZE)
                          * saturate(h & 'h7F, MAX_SECTION_SIZE);
            end
            if (band_px > 256) begin
                h = 1;
                band_px = saturate(w & 'h7F, MAX_SECTION_SIZE);
            end
            if (band_px > 64) begin
                count = band_px;
            end else begin
                count = band_px * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, band_px);
            end
            pause_at = -1;
            if (!paused && sent >= RANDOM_PIXELS / 2) begin
                pause_at = $urandom_range(0, count - 1);
                paused   = 1'b1;
            end
            run_region(w, h, c, r, count, pixel_mode_t'($urandom_range(0, 3)), pause_at);
            sent += count;
        end
    endtask

    // Back-to-back requests on both sides for the closing stretch.
    task automatic test_steady_stream();
        idle_on <= 1'b0;
        run_region(3, 2, 5, 2, 60, PIX_NOISE, -1);
        run_region(2, 3, 4, 3, 48, PIX_STEP, -1);
    endtask

    initial begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_restart_on_write();
        test_edge_search();
        test_register_saturation();
        test_large_sections();
        test_random_regions();
        test_steady_stream();

        // drain, then watch for strays for one full band walk
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("[section_mean_edge_locator] OK");
        end else begin
            $display("[section_mean_edge_locator] ERROR");
        end
        $finish;
    end

endmodule
